[rtl/core/gb3_pkg.sv]
// Shared constants, types and register codes of the 3x3 Gaussian blur unit.
package gb3_pkg;

   // Geometry limits
   localparam int MAX_WIDTH   = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 16;
   localparam int MIN_DIM     = 3;
   localparam int IMG_W_W     = 13;

   // Pixel and channel layout, red in the lowest byte
   localparam int CH_W        = 8;
   localparam int NUM_CH      = 3;
   localparam int PIX_W       = CH_W * NUM_CH;
   localparam int SUM_W       = CH_W + 2;
   localparam int CH_MAX      = (1 << CH_W) - 1;

   // Q0.16 weights and a Q12.16 accumulator
   localparam int COEF_W      = 16;
   localparam int FRAC_W      = 16;
   localparam int ACC_W       = SUM_W + COEF_W + 2;
   localparam int ROUND_ADD   = (1 << FRAC_W) - 1;

   // Results one pixel can cause
   localparam int EMIT_N      = 4;

   // Configuration port
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_EDGE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CORNER  = 3'd4;

   // Register reset values
   localparam int RESET_WIDTH       = 640;
   localparam int RESET_HEIGHT      = 480;
   localparam int RESET_COEF_CENTER = 13380;
   localparam int RESET_COEF_EDGE   = 8116;
   localparam int RESET_COEF_CORNER = 4924;

   typedef logic [PIX_W-1:0] pixel_type;

   // One line store entry: the two rows above the current one
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_entry_type;

   // Position info of an accepted pixel
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic              row_le1;
      logic              first_col;
      logic [EMIT_N-1:0] emit;
   } line_req_type;

   // Column loaded into the window
   typedef struct packed {
      pixel_type         cur;
      pixel_type         up1;
      pixel_type         up2;
      logic              first_col;
      logic [EMIT_N-1:0] emit;
   } win_load_type;

   typedef struct packed {
      logic [CH_W-1:0]  center;
      logic [SUM_W-1:0] side;
      logic [SUM_W-1:0] corner;
   } chan_sum_type;

   typedef struct packed {
      chan_sum_type [NUM_CH-1:0] chan;
      logic                      eof;
      logic                      last;
   } tap_job_type;

   typedef struct packed {
      logic [COEF_W-1:0] center;
      logic [COEF_W-1:0] side;
      logic [COEF_W-1:0] corner;
   } coef_set_type;

   typedef struct packed {
      logic [CH_W+COEF_W-1:0]  center;
      logic [SUM_W+COEF_W-1:0] side;
      logic [SUM_W+COEF_W-1:0] corner;
   } chan_prod_type;

   typedef struct packed {
      chan_prod_type [NUM_CH-1:0] chan;
      logic                       eof;
      logic                       last;
   } prod_job_type;

endpackage

[rtl/core/gb3_line_buf.sv]
// Two-row line store in one synchronous memory, read at accept and written back when the item leaves.
module gb3_line_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gb3_pkg::line_req_type req,
   input  gb3_pkg::pixel_type    pixel,
   output logic                  load_valid,
   input  logic                  load_ready,
   output gb3_pkg::win_load_type load
);
   import gb3_pkg::*;

   line_entry_type    mem [MAX_WIDTH];
   line_entry_type    rd_ff;
   logic              s1_valid_ff;
   pixel_type         s1_cur_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_row_le1_ff;
   logic              s1_first_ff;
   logic [EMIT_N-1:0] s1_emit_ff;
   logic              req_fire;
   logic              load_fire;
   pixel_type         up1;
   pixel_type         up2;

   // Take a pixel when the holding stage is empty or moves on this cycle
   assign req_ready = !s1_valid_ff || load_ready;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = s1_valid_ff && load_ready;

   // Rows above; on the first two rows the upper row repeats the nearer one
   assign up1 = rd_ff.newer;
   assign up2 = s1_row_le1_ff ? rd_ff.newer : rd_ff.older;

   // Read at accept, write back the shifted rows when the item leaves.
   // The same column returns only a full row later, after its write-back.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= mem[req.col];
      end
      if (load_fire) begin
         mem[s1_col_ff] <= '{older: up1, newer: s1_cur_ff};
      end
   end

   // Hold the item while its memory data arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cur_ff     <= pixel;
         s1_col_ff     <= req.col;
         s1_row_le1_ff <= req.row_le1;
         s1_first_ff   <= req.first_col;
         s1_emit_ff    <= req.emit;
      end
   end

   assign load_valid     = s1_valid_ff;
   assign load.cur       = s1_cur_ff;
   assign load.up1       = up1;
   assign load.up2       = up2;
   assign load.first_col = s1_first_ff;
   assign load.emit      = s1_emit_ff;

endmodule

[rtl/core/gb3_window.sv]
// 3x3 pixel window and the sequencer that issues one result's tap sums per cycle unless job_ready holds it back.
module gb3_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  gb3_pkg::win_load_type load,
   output logic                  job_valid,
   input  logic                  job_ready,
   output gb3_pkg::tap_job_type  job
);
   import gb3_pkg::*;

   localparam logic [1:0] PICK_FRAME_END = 2'd3;

   pixel_type         win_ff [3][3];
   pixel_type         win_in [3][3];
   pixel_type         tap    [3][3];
   pixel_type         vals   [3];
   logic [EMIT_N-1:0] mask_ff;
   logic [EMIT_N-1:0] mask_in;
   logic [EMIT_N-1:0] mask_clr;
   logic [EMIT_N-1:0] mask_left;
   logic [1:0]        pick;
   logic              issue;
   logic              load_fire;

   // Pick the next pending result, raster order
   always_comb begin
      if (mask_ff[0]) begin
         pick = 2'd0;
      end else if (mask_ff[1]) begin
         pick = 2'd1;
      end else if (mask_ff[2]) begin
         pick = 2'd2;
      end else begin
         pick = PICK_FRAME_END;
      end
   end

   assign job_valid = |mask_ff;
   assign issue     = job_valid && job_ready;
   assign mask_clr  = mask_ff & (mask_ff - 1'b1);
   assign mask_left = issue ? mask_clr : mask_ff;

   // Load the next column once the last result of this one is out
   assign load_ready = (mask_left == '0);
   assign load_fire  = load_valid && load_ready;
   assign mask_in    = load_fire ? load.emit : mask_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // Shift the window left, or fill all three columns at a row start
   always_comb begin
      vals[0] = load.up2;
      vals[1] = load.up1;
      vals[2] = load.cur;
      for (int k = 0; k < 3; k++) begin
         if (load.first_col) begin
            win_in[k][0] = vals[k];
            win_in[k][1] = vals[k];
         end else begin
            win_in[k][0] = win_ff[k][1];
            win_in[k][1] = win_ff[k][2];
         end
         win_in[k][2] = vals[k];
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         win_ff <= win_in;
      end
   end

   // Bottom and right borders repeat the last row or column of the window
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            tap[j][i] = win_ff[(pick[1] && j < 2) ? j + 1 : j][(pick[0] && i < 2) ? i + 1 : i];
         end
      end
   end

   // Center, side and corner sums per channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         job.chan[ch].center = tap[1][1][ch*CH_W +: CH_W];
         job.chan[ch].side   = SUM_W'(tap[0][1][ch*CH_W +: CH_W])
                             + SUM_W'(tap[2][1][ch*CH_W +: CH_W])
                             + SUM_W'(tap[1][0][ch*CH_W +: CH_W])
                             + SUM_W'(tap[1][2][ch*CH_W +: CH_W]);
         job.chan[ch].corner = SUM_W'(tap[0][0][ch*CH_W +: CH_W])
                             + SUM_W'(tap[0][2][ch*CH_W +: CH_W])
                             + SUM_W'(tap[2][0][ch*CH_W +: CH_W])
                             + SUM_W'(tap[2][2][ch*CH_W +: CH_W]);
      end
      job.eof  = (pick == PICK_FRAME_END);
      job.last = (mask_clr == '0);
   end

endmodule

[rtl/core/gb3_mac.sv]
// Weighting pipeline: tap sums, products with Q0.16 weights, ceiling and saturation, output register.
module gb3_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  gb3_pkg::coef_set_type coef,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  gb3_pkg::tap_job_type  job,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [gb3_pkg::PIX_W-1:0] rsp_tdata,   // out_red, out_green, out_blue
   output logic                  rsp_tuser,       // end_of_frame
   output logic                  rsp_tlast        // last_of_run
);
   import gb3_pkg::*;

   logic                 a_valid_ff;
   tap_job_type          a_job_ff;
   logic                 m_valid_ff;
   prod_job_type         m_job_ff;
   prod_job_type         m_job_in;
   logic                 o_valid_ff;
   pixel_type            o_data_ff;
   pixel_type            o_data_in;
   logic                 o_eof_ff;
   logic                 o_last_ff;
   logic                 o_ready;
   logic                 m_ready;
   logic                 a_ready;
   logic [ACC_W-1:0]     acc   [NUM_CH];
   logic [ACC_W-FRAC_W-1:0] quot [NUM_CH];

   // Each stage moves when the one after it is empty or moving
   assign o_ready   = !o_valid_ff || rsp_tready;
   assign m_ready   = !m_valid_ff || o_ready;
   assign a_ready   = !a_valid_ff || m_ready;
   assign job_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= job_valid;
         end
         if (m_ready) begin
            m_valid_ff <= a_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   // Weight the three sums of each channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         m_job_in.chan[ch].center = a_job_ff.chan[ch].center * coef.center;
         m_job_in.chan[ch].side   = a_job_ff.chan[ch].side * coef.side;
         m_job_in.chan[ch].corner = a_job_ff.chan[ch].corner * coef.corner;
      end
      m_job_in.eof  = a_job_ff.eof;
      m_job_in.last = a_job_ff.last;
   end

   // Add, round up to an integer, clamp at full scale
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         acc[ch]  = ACC_W'(m_job_ff.chan[ch].center) + ACC_W'(m_job_ff.chan[ch].side)
                  + ACC_W'(m_job_ff.chan[ch].corner) + ACC_W'(ROUND_ADD);
         quot[ch] = acc[ch][ACC_W-1:FRAC_W];
         o_data_in[ch*CH_W +: CH_W] = (quot[ch] > CH_MAX) ? CH_W'(CH_MAX)
                                                          : quot[ch][CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && job_valid) begin
         a_job_ff <= job;
      end
      if (m_ready && a_valid_ff) begin
         m_job_ff <= m_job_in;
      end
      if (o_ready && m_valid_ff) begin
         o_data_ff <= o_data_in;
         o_eof_ff  <= m_job_ff.eof;
         o_last_ff <= m_job_ff.last;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_eof_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

[rtl/core/gaussian_blur_3x3_rgb_unit.sv]
// Top level of the 3x3 Gaussian blur unit: configuration registers, raster counters, datapath.
//
// RGB pixels enter in raster order, one per clock unless held, and leave blurred by a
// symmetric 3x3 kernel with Q0.16 weights, edge pixels replicated at the borders. Results
// trail the input by one row and one column; a row end also flushes the owed last-column
// pixel and the final row flushes its own pixels, so one input causes up to four results,
// flagged end of frame on the frame's last pixel and last of run on the last result of each
// input. The unit takes one pixel per clock while each pixel causes at most one result;
// results leave one per clock while the output is not stalled, so a row-end or final-row
// pixel holds the input until its extra results are issued. That pace is set by the window
// sequencer, which issues one result per cycle into the weighting pipeline while it is ready.
// A pixel's first result passes the holding stage, the window register and the stages a, m
// and o of the weighting pipeline. The two rows above are kept in one line memory read at
// accept and written back as the pixel moves on; no clearing pass is needed after reset.
// Configuration writes are taken in any cycle and must only be made while the unit is idle.
module gaussian_blur_3x3_rgb_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gb3_pkg::PIX_W-1:0]         req_tdata,   // in_red, in_green, in_blue
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gb3_pkg::PIX_W-1:0]         rsp_tdata,   // out_red, out_green, out_blue
   output logic                              rsp_tuser,   // end_of_frame
   output logic                              rsp_tlast,   // last_of_run
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gb3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gb3_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gb3_pkg::*;

   logic [COL_W-1:0]   last_col_ff;
   logic [COL_W-1:0]   last_col_in;
   logic [ROW_W-1:0]   last_row_ff;
   logic [ROW_W-1:0]   last_row_in;
   coef_set_type       coef_ff;
   coef_set_type       coef_in;
   logic [IMG_W_W-1:0] width_val;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic               req_fire;
   logic               row_end;
   logic               last_row;
   logic               row_ge1;
   logic               col_ge1;
   line_req_type       line_req;
   logic               load_valid;
   logic               load_ready;
   win_load_type       load;
   logic               job_valid;
   logic               job_ready;
   tap_job_type        job;

   // Configuration: store the clamped last column and row index
   assign csr_ready = 1'b1;
   assign width_val = csr_wdata[IMG_W_W-1:0];

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      coef_in     = coef_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (width_val < MIN_DIM) begin
                  last_col_in = COL_W'(MIN_DIM - 1);
               end else if (width_val > MAX_WIDTH) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_W'(width_val - 1'b1);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_wdata < MIN_DIM) begin
                  last_row_in = ROW_W'(MIN_DIM - 1);
               end else begin
                  last_row_in = csr_wdata - 1'b1;
               end
            end
            CSR_COEF_CENTER: coef_in.center = csr_wdata;
            CSR_COEF_EDGE:   coef_in.side   = csr_wdata;
            CSR_COEF_CORNER: coef_in.corner = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff    <= COL_W'(RESET_WIDTH - 1);
         last_row_ff    <= ROW_W'(RESET_HEIGHT - 1);
         coef_ff.center <= COEF_W'(RESET_COEF_CENTER);
         coef_ff.side   <= COEF_W'(RESET_COEF_EDGE);
         coef_ff.corner <= COEF_W'(RESET_COEF_CORNER);
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         coef_ff     <= coef_in;
      end
   end

   // Raster position of the next pixel and the results it owes
   assign req_fire = req_tvalid && req_tready;
   assign row_end  = (col_ff >= last_col_ff);
   assign last_row = (row_ff >= last_row_ff);
   assign row_ge1  = (row_ff != '0);
   assign col_ge1  = (col_ff != '0);

   assign line_req.col       = col_ff;
   assign line_req.row_le1   = !row_ge1 || (row_ff == ROW_W'(1));
   assign line_req.first_col = !col_ge1;
   assign line_req.emit      = {last_row && row_end, last_row && col_ge1,
                                row_ge1 && row_end, row_ge1 && col_ge1};

   // Advance column, wrap to the next row at a row end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   gb3_line_buf u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (line_req),
      .pixel      (req_tdata),
      .load_valid (load_valid),
      .load_ready (load_ready),
      .load       (load)
   );

   gb3_window u_window (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_ready (load_ready),
      .load       (load),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   gb3_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/core/gb3_checker.sv]
// Port-level checks of the blur unit and their binding to the top level.
module gb3_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [gb3_pkg::PIX_W-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      rsp_tlast
);

   // Hold a stalled result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // End of frame closes the run of its pixel
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame without last of run");

   // Results of one pixel leave without gaps
   a_run_dense: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a run of results");

   // Come out of reset empty and ready for a pixel
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("unit not empty after reset");

endmodule

bind gaussian_blur_3x3_rgb_unit gb3_checker u_gb3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
